// ===== rtl/core/assert_macros.svh =====
// Assertion macros included by the RTL file jms_back.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define JMS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define JMS_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error("%m failed");
`else
`define JMS_ASSERT(label, clk, rst_n, prop)
`define JMS_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ===== rtl/core/jms_pkg.sv =====
// ----------------------------------------------------------------------------
// jms_pkg
// Types, constants and joint limit tables for the joint move stepper.
// ----------------------------------------------------------------------------
package jms_pkg;

    localparam int MAX_JOINTS = 8;
    localparam int TARGET_FIELDS = 5;
    localparam int JOINTS_DEFAULT = 5;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 12;
    localparam logic [16:0] GAIN_ONE = 17'd65536;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_PER_TICK = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_JOINT_TOL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EE_STEP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EE_TOL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EE_MIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_EE_MAX = 3'd5;

    typedef struct packed {
        logic        kind;
        logic [15:0] target_j0;
        logic [15:0] target_j1;
        logic [15:0] target_j2;
        logic [15:0] target_j3;
        logic [15:0] target_j4;
        logic [10:0] target_ee;
    } in_word_t;

    typedef struct packed {
        logic [15:0] pos_j0;
        logic [15:0] pos_j1;
        logic [15:0] pos_j2;
        logic [15:0] pos_j3;
        logic [15:0] pos_j4;
        logic [10:0] pos_ee;
        logic        done_res;
    } out_word_t;

    typedef struct packed {
        logic [11:0] step_per_tick;
        logic [11:0] joint_tolerance;
        logic [7:0]  ee_step;
        logic [7:0]  ee_tolerance;
        logic [10:0] ee_min;
        logic [10:0] ee_max;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TARGET,
        ST_DIV,
        ST_TICK,
        ST_OUT
    } back_state_t;

    function automatic logic [15:0] lim_lo(input int j);
        return (j == 0) ? 16'd715 : 16'd0;
    endfunction

    function automatic logic [15:0] lim_hi(input int j);
        case (j)
            0: return 16'd12153;
            1: return 16'd9294;
            2: return 16'd19302;
            3: return 16'd12868;
            4: return 16'd12868;
            default: return 16'd65535;
        endcase
    endfunction

    function automatic logic [15:0] home_pose(input int j);
        case (j)
            0: return 16'd6434;
            3: return 16'd11438;
            4: return 16'd12868;
            default: return 16'd0;
        endcase
    endfunction

endpackage

// ===== rtl/core/jms_front.sv =====
// ----------------------------------------------------------------------------
// jms_front
// Input stage: accepts words and keeps a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module jms_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  jms_pkg::in_word_t in_word,
    output logic              q_valid,
    input  logic              q_ready,
    output jms_pkg::in_word_t q_word
);
    import jms_pkg::*;

    in_word_t   mem_reg [2];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_word   = mem_reg[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= in_word;
        end
    end

endmodule

// ===== rtl/core/jms_div.sv =====
// ----------------------------------------------------------------------------
// jms_div
// Restoring divider: (step << 16) / largest, one quotient bit per cycle,
// saturated to one in Q16.
// ----------------------------------------------------------------------------
module jms_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [11:0] step,
    input  logic [16:0] divisor,
    output logic        busy,
    output logic [16:0] gain
);
    import jms_pkg::*;

    logic [27:0] num_reg, num_next;
    logic [17:0] rem_reg, rem_next;
    logic [16:0] dvs_reg, dvs_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [17:0] trial;
    logic [18:0] diff;

    assign busy  = busy_reg;
    assign trial = {rem_reg[16:0], num_reg[27]};
    assign diff  = {1'b0, trial} - {2'b00, dvs_reg};
    assign gain  = (num_reg[27:17] != 11'd0 || num_reg[16:0] > GAIN_ONE) ?
                   GAIN_ONE : num_reg[16:0];

    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            num_next  = {step, 16'd0};
            rem_next  = 18'd0;
            dvs_next  = divisor;
            cnt_next  = 5'd28;
            busy_next = (divisor != 17'd0);
            if (divisor == 17'd0)
            begin
                num_next = 28'd0;
            end
        end
        else if (busy_reg)
        begin
            if (!diff[18])
            begin
                rem_next = diff[17:0];
                num_next = {num_reg[26:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                num_next = {num_reg[26:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 5'd0;
            num_reg  <= 28'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            num_reg  <= num_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

endmodule

// ===== rtl/core/jms_back.sv =====
// ----------------------------------------------------------------------------
// jms_back
// Motion engine: takes targets and ticks from the queue, updates the pose
// and presents one result word per item.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jms_back #(
    parameter int JOINTS = jms_pkg::JOINTS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  jms_pkg::cfg_t      cfg,
    input  logic               q_valid,
    output logic               q_ready,
    input  jms_pkg::in_word_t  q_word,
    output logic               out_valid,
    input  logic               out_ready,
    output jms_pkg::out_word_t out_word
);
    import jms_pkg::*;

    localparam int JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

    back_state_t       state_reg, state_next;
    logic [15:0]       pos_reg [JOINTS];
    logic signed [16:0] err_reg [JOINTS];
    logic [10:0]       ee_pos_reg;
    logic signed [11:0] ee_err_reg;
    logic [16:0]       gain_reg;
    logic              settled_reg, all_in_reg;
    in_word_t          item_reg;
    logic [16:0]       largest_reg;
    logic [JW-1:0]     j_reg;
    logic [33:0]       prod_reg;
    logic              prod_vld_reg;
    logic              div_start, div_busy;
    logic [16:0]       div_gain;
    logic [16:0]       div_divisor;

    logic [15:0]       tgt;
    logic signed [16:0] cur_err, new_err;
    logic [16:0]       cur_mag, d;
    logic [16:0]       tmag;
    logic [11:0]       ee_mag, ed;
    logic [11:0]       ee_tgt;
    logic signed [11:0] ee_sd;

    jms_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .step    (cfg.step_per_tick),
        .divisor (div_divisor),
        .busy    (div_busy),
        .gain    (div_gain)
    );

    assign q_ready     = (state_reg == ST_IDLE);
    assign out_valid   = (state_reg == ST_OUT);
    assign div_start   = (state_reg == ST_TARGET) && (j_reg == JW'(JOINTS - 1));
    assign div_divisor = (tmag > largest_reg) ? tmag : largest_reg;

    always_comb
    begin
        out_word = '0;
        out_word.pos_j0 = pos_reg[0];
        if (JOINTS > 1) out_word.pos_j1 = pos_reg[1 % JOINTS];
        if (JOINTS > 2) out_word.pos_j2 = pos_reg[2 % JOINTS];
        if (JOINTS > 3) out_word.pos_j3 = pos_reg[3 % JOINTS];
        if (JOINTS > 4) out_word.pos_j4 = pos_reg[4 % JOINTS];
        out_word.pos_ee   = ee_pos_reg;
        out_word.done_res = settled_reg;
    end

    always_comb
    begin
        unique case (j_reg)
            default: tgt = pos_reg[j_reg];
        endcase
        if (32'(j_reg) == 0) tgt = item_reg.target_j0;
        if (32'(j_reg) == 1) tgt = item_reg.target_j1;
        if (32'(j_reg) == 2) tgt = item_reg.target_j2;
        if (32'(j_reg) == 3) tgt = item_reg.target_j3;
        if (32'(j_reg) == 4) tgt = item_reg.target_j4;
        if (32'(j_reg) >= TARGET_FIELDS) tgt = pos_reg[j_reg];
        if (tgt < lim_lo(32'(j_reg))) tgt = lim_lo(32'(j_reg));
        if (tgt > lim_hi(32'(j_reg))) tgt = lim_hi(32'(j_reg));
        tmag = ({1'b0, tgt} >= {1'b0, pos_reg[j_reg]}) ?
               ({1'b0, tgt} - {1'b0, pos_reg[j_reg]}) :
               ({1'b0, pos_reg[j_reg]} - {1'b0, tgt});
        cur_err = err_reg[j_reg];
        cur_mag = cur_err[16] ? 17'(-cur_err) : 17'(cur_err);
        d = 17'(prod_reg >> 16);
        if (d == 17'd0) d = 17'd1;
        if (d > cur_mag) d = cur_mag;
        new_err = cur_err[16] ? (cur_err + 17'(d)) : (cur_err - 17'(d));
        ee_tgt = {1'b0, item_reg.target_ee};
        if (ee_tgt < {1'b0, cfg.ee_min}) ee_tgt = {1'b0, cfg.ee_min};
        if (ee_tgt > {1'b0, cfg.ee_max}) ee_tgt = {1'b0, cfg.ee_max};
        ee_mag = ee_err_reg[11] ? 12'(-ee_err_reg) : 12'(ee_err_reg);
        ed = 12'd0;
        if (cfg.ee_step != 8'd0 && ee_mag >= {4'd0, cfg.ee_step}) ed = {4'd0, cfg.ee_step};
        else if (ee_mag > {4'd0, cfg.ee_tolerance}) ed = ee_mag;
        ee_sd = ee_err_reg[11] ? -$signed(ed) : $signed(ed);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    if (!q_word.kind && settled_reg) state_next = ST_TARGET;
                    else if (q_word.kind && !settled_reg) state_next = ST_TICK;
                    else state_next = ST_OUT;
                end
            end
            ST_TARGET:
            begin
                if (j_reg == JW'(JOINTS - 1)) state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (!div_busy) state_next = ST_OUT;
            end
            ST_TICK:
            begin
                if (prod_vld_reg && j_reg == JW'(JOINTS - 1)) state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            j_reg        <= '0;
            prod_vld_reg <= 1'b0;
            settled_reg  <= 1'b1;
            all_in_reg   <= 1'b1;
            gain_reg     <= 17'd0;
            ee_pos_reg   <= 11'd1200;
            ee_err_reg   <= 12'sd0;
            largest_reg  <= 17'd0;
            item_reg     <= '0;
            for (int j = 0; j < JOINTS; j++)
            begin
                pos_reg[j] <= home_pose(j);
                err_reg[j] <= 17'sd0;
            end
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE:
                begin
                    j_reg        <= '0;
                    largest_reg  <= 17'd0;
                    prod_vld_reg <= 1'b0;
                    all_in_reg   <= 1'b1;
                    if (q_valid) item_reg <= q_word;
                end
                ST_TARGET:
                begin
                    err_reg[j_reg] <= 17'(signed'({1'b0, tgt}) - signed'({1'b0, pos_reg[j_reg]}));
                    if (tmag > largest_reg) largest_reg <= tmag;
                    ee_err_reg  <= signed'(ee_tgt) - signed'({1'b0, ee_pos_reg});
                    settled_reg <= 1'b0;
                    if (j_reg != JW'(JOINTS - 1)) j_reg <= j_reg + JW'(1);
                end
                ST_DIV:
                begin
                    if (!div_busy) gain_reg <= div_gain;
                end
                ST_TICK:
                begin
                    if (!prod_vld_reg)
                    begin
                        prod_reg     <= 34'(cur_mag) * 34'(gain_reg);
                        prod_vld_reg <= 1'b1;
                    end
                    else
                    begin
                        prod_vld_reg <= 1'b0;
                        if (cur_mag > {5'd0, cfg.joint_tolerance})
                        begin
                            pos_reg[j_reg] <= 16'(pos_reg[j_reg] + 16'(cur_err - new_err));
                            err_reg[j_reg] <= new_err;
                            if ((new_err[16] ? 17'(-new_err) : 17'(new_err))
                                > {5'd0, cfg.joint_tolerance}) all_in_reg <= 1'b0;
                        end
                        else if (cur_mag > {5'd0, cfg.joint_tolerance})
                        begin
                            all_in_reg <= 1'b0;
                        end
                        if (j_reg != JW'(JOINTS - 1))
                        begin
                            j_reg <= j_reg + JW'(1);
                        end
                        else
                        begin
                            ee_pos_reg <= 11'(ee_pos_reg + 11'(ee_sd));
                            ee_err_reg <= ee_err_reg - ee_sd;
                            settled_reg <= all_in_reg
                                && (((new_err[16] ? 17'(-new_err) : 17'(new_err))
                                     <= {5'd0, cfg.joint_tolerance})
                                    || cur_mag <= {5'd0, cfg.joint_tolerance})
                                && ((ee_err_reg[11] ? 12'(-(ee_err_reg - ee_sd))
                                     : 12'(ee_err_reg - ee_sd)) <= {4'd0, cfg.ee_tolerance});
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    `JMS_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid)
    `JMS_ASSERT(a_div_only_in_div, clk, rst_n, div_busy |-> state_reg == ST_DIV)
    `JMS_ASSERT(a_gain_sat, clk, rst_n, gain_reg <= GAIN_ONE)
    `JMS_ASSERT_NEVER(a_take_busy, clk, rst_n, q_ready && out_valid)

endmodule

// ===== rtl/core/joint_move_stepper.sv =====
// A tick computes a product and then a step for each joint in turn, then
// presents its result word. A target computes each joint's error in turn, then
// waits for the bit-serial gain divider; an ignored item goes straight to output.
// One item is processed at a time; a two-word input queue accepts words until full.
// Reset is asynchronous and active low and restores the home pose, settled.
// ----------------------------------------------------------------------------
// joint_move_stepper
// Steps joint angles and the gripper toward a clamped target.
// ----------------------------------------------------------------------------
module joint_move_stepper #(
    parameter int JOINTS = jms_pkg::JOINTS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [jms_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [jms_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  jms_pkg::in_word_t                in_word,
    output logic                             out_valid,
    input  logic                             out_ready,
    output jms_pkg::out_word_t               out_word
);
    import jms_pkg::*;

    cfg_t     cfg_reg;
    logic     q_valid, q_ready;
    in_word_t q_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_per_tick   <= 12'd717;
            cfg_reg.joint_tolerance <= 12'd1229;
            cfg_reg.ee_step         <= 8'd3;
            cfg_reg.ee_tolerance    <= 8'd3;
            cfg_reg.ee_min          <= 11'd800;
            cfg_reg.ee_max          <= 11'd1300;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_STEP_PER_TICK: cfg_reg.step_per_tick   <= cfg_data;
                REG_JOINT_TOL:     cfg_reg.joint_tolerance <= cfg_data;
                REG_EE_STEP:       cfg_reg.ee_step         <= cfg_data[7:0];
                REG_EE_TOL:        cfg_reg.ee_tolerance    <= cfg_data[7:0];
                REG_EE_MIN:        cfg_reg.ee_min          <= cfg_data[10:0];
                REG_EE_MAX:        cfg_reg.ee_max          <= cfg_data[10:0];
                default:
                begin
                end
            endcase
        end
    end

    jms_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_word  (in_word),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_word   (q_word)
    );

    jms_back #(
        .JOINTS (JOINTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_word    (q_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Joint move stepper testbench
// Drives target and tick words through the input handshake, predicts each
// result word with a behavioral model of the stepper, and compares every
// result field by field. Registers are rewritten between phases while idle.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import jms_pkg::*;

    localparam int NJ = 5;
    localparam int CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    in_word_t in_word;
    logic out_valid;
    logic out_ready;
    out_word_t out_word;

    joint_move_stepper dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
        .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word)
    );

    // Model state.
    logic [11:0] m_step;
    logic [11:0] m_jtol;
    logic [7:0] m_eestep;
    logic [7:0] m_eetol;
    logic [10:0] m_eemin;
    logic [10:0] m_eemax;
    logic [15:0] m_pos [NJ];
    int m_err [NJ];
    logic [10:0] m_ee;
    int m_eeerr;
    longint m_gain;
    logic m_settled;

    in_word_t pending_words [$];
    out_word_t expected_words [$];
    int errors = 0;
    int cycles = 0;
    bit quiet = 0;
    bit hold_sink = 0;
    int src_gap = 0;
    int sink_gap = 0;

    function automatic int iabs(int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic void model_reset();
        m_step = 717; m_jtol = 1229; m_eestep = 3; m_eetol = 3;
        m_eemin = 800; m_eemax = 1300;
        for (int j = 0; j < NJ; j++)
        begin
            m_pos[j] = home_pose(j);
            m_err[j] = 0;
        end
        m_ee = 1200; m_eeerr = 0; m_gain = 0; m_settled = 1;
    endfunction

    function automatic void model_config(logic [CFG_IDX_W-1:0] idx, logic [11:0] v);
        case (idx)
            REG_STEP_PER_TICK: m_step = v;
            REG_JOINT_TOL: m_jtol = v;
            REG_EE_STEP: m_eestep = v[7:0];
            REG_EE_TOL: m_eetol = v[7:0];
            REG_EE_MIN: m_eemin = v[10:0];
            REG_EE_MAX: m_eemax = v[10:0];
            default: ;
        endcase
    endfunction

    function automatic out_word_t stepper_next(in_word_t w);
        logic [15:0] tg [NJ];
        int largest;
        int t;
        int a;
        int d;
        int ea;
        int ed;
        bit all_in;
        out_word_t r;
        tg[0] = w.target_j0; tg[1] = w.target_j1; tg[2] = w.target_j2;
        tg[3] = w.target_j3; tg[4] = w.target_j4;
        if (w.kind == 1'b0)
        begin
            if (m_settled)
            begin
                largest = 0;
                for (int j = 0; j < NJ; j++)
                begin
                    t = tg[j];
                    if (t < lim_lo(j)) t = lim_lo(j);
                    if (t > lim_hi(j)) t = lim_hi(j);
                    m_err[j] = t - int'(m_pos[j]);
                    if (iabs(m_err[j]) > largest) largest = iabs(m_err[j]);
                end
                if (largest == 0)
                    m_gain = 0;
                else
                begin
                    m_gain = (longint'(m_step) << 16) / largest;
                    if (m_gain > 65536) m_gain = 65536;
                end
                t = w.target_ee;
                if (t < m_eemin) t = m_eemin;
                if (t > m_eemax) t = m_eemax;
                m_eeerr = t - int'(m_ee);
                m_settled = 0;
            end
        end
        else if (!m_settled)
        begin
            all_in = 1;
            for (int j = 0; j < NJ; j++)
            begin
                a = iabs(m_err[j]);
                if (a > m_jtol)
                begin
                    d = int'((longint'(a) * m_gain) >>> 16);
                    if (d == 0) d = 1;
                    if (d > a) d = a;
                    if (m_err[j] < 0) d = -d;
                    m_pos[j] = m_pos[j] + d[15:0];
                    m_err[j] -= d;
                end
                if (iabs(m_err[j]) > m_jtol) all_in = 0;
            end
            ea = iabs(m_eeerr);
            ed = 0;
            if (m_eestep != 0 && ea >= m_eestep) ed = m_eestep;
            else if (ea > m_eetol) ed = ea;
            if (ed != 0)
            begin
                if (m_eeerr < 0) ed = -ed;
                m_ee = m_ee + ed[10:0];
                m_eeerr -= ed;
            end
            if (iabs(m_eeerr) > m_eetol) all_in = 0;
            m_settled = all_in;
        end
        r.pos_j0 = m_pos[0]; r.pos_j1 = m_pos[1]; r.pos_j2 = m_pos[2];
        r.pos_j3 = m_pos[3]; r.pos_j4 = m_pos[4];
        r.pos_ee = m_ee; r.done_res = m_settled;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_word <= '0;
            src_gap <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_words.push_back(stepper_next(in_word));
            if (!in_valid || in_ready)
            begin
                if (src_gap > 0)
                begin
                    src_gap <= src_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_words.size() > 0)
                begin
                    in_valid <= 1'b1;
                    in_word <= pending_words.pop_front();
                    if (!quiet && $urandom_range(0, 9) == 0)
                        src_gap <= $urandom_range(1, 13);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor.
    always @(posedge clk or negedge rst_n)
    begin
        out_word_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            sink_gap <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $display("MISMATCH unexpected result word at cycle %0d", cycles);
                    errors++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (out_word.pos_j0 !== want.pos_j0)
                        report_mismatch("pos_j0", out_word.pos_j0, want.pos_j0);
                    if (out_word.pos_j1 !== want.pos_j1)
                        report_mismatch("pos_j1", out_word.pos_j1, want.pos_j1);
                    if (out_word.pos_j2 !== want.pos_j2)
                        report_mismatch("pos_j2", out_word.pos_j2, want.pos_j2);
                    if (out_word.pos_j3 !== want.pos_j3)
                        report_mismatch("pos_j3", out_word.pos_j3, want.pos_j3);
                    if (out_word.pos_j4 !== want.pos_j4)
                        report_mismatch("pos_j4", out_word.pos_j4, want.pos_j4);
                    if (out_word.pos_ee !== want.pos_ee)
                        report_mismatch("pos_ee", out_word.pos_ee, want.pos_ee);
                    if (out_word.done_res !== want.done_res)
                        report_mismatch("done_res", out_word.done_res, want.done_res);
                end
            end
            if (hold_sink)
                out_ready <= 1'b0;
            else if (sink_gap > 0)
            begin
                sink_gap <= sink_gap - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 9) == 0)
                    sink_gap <= $urandom_range(1, 13);
            end
        end
    end

    function automatic in_word_t make_target(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                                             logic [15:0] d, logic [15:0] e, logic [10:0] g);
        in_word_t w;
        w.kind = 1'b0;
        w.target_j0 = a; w.target_j1 = b; w.target_j2 = c;
        w.target_j3 = d; w.target_j4 = e; w.target_ee = g;
        return w;
    endfunction

    function automatic in_word_t make_tick();
        in_word_t w;
        w = in_word_t'($bits(in_word_t)'({$urandom, $urandom, $urandom}));
        w.kind = 1'b1;
        return w;
    endfunction

    function automatic in_word_t random_target();
        return make_target(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                           16'($urandom), 11'($urandom));
    endfunction

    task automatic wait_drained();
        while (pending_words.size() > 0 || in_valid || expected_words.size() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [11:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        model_config(idx, v);
    endtask

    task automatic set_all(int s, int jt, int es, int et, int lo, int hi);
        write_reg(REG_STEP_PER_TICK, 12'(s));
        write_reg(REG_JOINT_TOL, 12'(jt));
        write_reg(REG_EE_STEP, 12'(es));
        write_reg(REG_EE_TOL, 12'(et));
        write_reg(REG_EE_MIN, 12'(lo));
        write_reg(REG_EE_MAX, 12'(hi));
    endtask

    // A target followed by enough ticks to settle most of the time.
    task automatic queue_move(int nticks);
        pending_words.push_back(random_target());
        repeat (nticks) pending_words.push_back(make_tick());
    endtask

    initial
    begin
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        rst_n = 1'b0;
        model_reset();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with reset settings.
        pending_words.push_back(make_tick());
        pending_words.push_back(make_target(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 11'd0));
        pending_words.push_back(make_target(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                            16'hFFFF, 11'h7FF));
        repeat (6) pending_words.push_back(make_tick());
        pending_words.push_back(make_target(16'd6434, 16'd0, 16'd0, 16'd11438,
                                            16'd12868, 11'd1200));
        pending_words.push_back(make_tick());
        pending_words.push_back(make_tick());
        wait_drained();

        // Tiny step forces one-LSB moves, big gripper step, inverted gripper window.
        set_all(1, 0, 255, 0, 1500, 900);
        pending_words.push_back(make_target(16'd6440, 16'd3, 16'd0, 16'd11430,
                                            16'd12868, 11'd0));
        repeat (10) pending_words.push_back(make_tick());
        wait_drained();

        // Large step saturates the gain.
        set_all(4095, 4095, 1, 255, 0, 2047);
        pending_words.push_back(make_target(16'd700, 16'd20, 16'd0, 16'd0, 16'd0, 11'd2047));
        repeat (4) pending_words.push_back(make_tick());
        wait_drained();

        // Long receiver hold while words keep coming.
        set_all(717, 1229, 3, 3, 800, 1300);
        hold_sink = 1;
        repeat (3) queue_move(8);
        repeat (300) @(posedge clk);
        hold_sink = 0;
        wait_drained();

        // Random phases across several register settings.
        for (int phase = 0; phase < 5; phase++)
        begin
            set_all($urandom_range(1, 4095), $urandom_range(0, 4095),
                    $urandom_range(1, 255), $urandom_range(0, 255),
                    $urandom_range(0, 2047), $urandom_range(0, 2047));
            if (phase == 4)
                quiet = 1;
            for (int k = 0; k < 12; k++)
            begin
                if ($urandom_range(0, 4) == 0)
                    pending_words.push_back(random_target());
                else
                    queue_move($urandom_range(2, 12));
            end
            wait_drained();
        end

        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
